// ===== hdl/ca3g_pkg.sv =====
// ----------------------------------------------------------------------------
// ca3g_pkg
// Shared types and constants of the 3D Generations cellular automaton.
// ----------------------------------------------------------------------------
package ca3g_pkg;

  localparam int SIDE_DEFAULT = 16;
  localparam int COORD_W      = 4;
  localparam int STATE_W      = 3;
  localparam int MASK_W       = 27;
  localparam int COUNT_W      = 4;
  localparam int NBR_W        = 5;
  localparam int CENTER_K     = 1;

  localparam logic [1:0] REG_BIRTH   = 2'd0;
  localparam logic [1:0] REG_SURVIVE = 2'd1;
  localparam logic [1:0] REG_STATES  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_GEN   = 2'd2,
    FUNC_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 in_cube;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic [STATE_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]  birth;
    logic [MASK_W-1:0]  survive;
    logic [COUNT_W-1:0] state_count;
  } cfg_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_GEN_RD,
    ST_GEN_ACC,
    ST_GEN_WR,
    ST_RESP
  } back_state_t;

  function automatic logic [STATE_W-1:0] top_of(input logic [COUNT_W-1:0] n);
    logic [STATE_W-1:0] t;
    if (n < COUNT_W'(2))      t = STATE_W'(1);
    else if (n > COUNT_W'(8)) t = STATE_W'(7);
    else                      t = STATE_W'(n - COUNT_W'(1));
    return t;
  endfunction

endpackage

// ===== hdl/ca3g_front.sv =====
// ----------------------------------------------------------------------------
// ca3g_front
// Accepts items, decodes the function and bounds, and queues them.
// ----------------------------------------------------------------------------
module ca3g_front #(
  parameter int SIDE = ca3g_pkg::SIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [ca3g_pkg::COORD_W-1:0]  pos_x,
  input  logic [ca3g_pkg::COORD_W-1:0]  pos_y,
  input  logic [ca3g_pkg::COORD_W-1:0]  pos_z,
  input  logic [ca3g_pkg::STATE_W-1:0]  cell_value,
  input  ca3g_pkg::back_status_t        status,
  output logic                          q_valid,
  output ca3g_pkg::item_t               q_item,
  input  logic                          q_pop
);
  import ca3g_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      dec;

  always_comb begin
    dec.op      = op_t'(func);
    dec.in_cube = (int'(pos_x) < SIDE) && (int'(pos_y) < SIDE) && (int'(pos_z) < SIDE);
    dec.x       = pos_x;
    dec.y       = pos_y;
    dec.z       = pos_z;
    dec.value   = cell_value;
  end

  assign in_ready = (fill != 2'd2) && !status.init_busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/ca3g_back.sv =====
// ----------------------------------------------------------------------------
// ca3g_back
// Executes queued items against the two cell buffers and drives results.
// ----------------------------------------------------------------------------
module ca3g_back #(
  parameter int SIDE = ca3g_pkg::SIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ca3g_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  ca3g_pkg::item_t               q_item,
  output logic                          q_pop,
  output ca3g_pkg::back_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ca3g_pkg::STATE_W-1:0]  read_value,
  output logic                          done_res
);
  import ca3g_pkg::*;

  localparam int CELLS = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SIDE);

  logic [STATE_W-1:0] mem_even [CELLS];
  logic [STATE_W-1:0] mem_odd  [CELLS];
  logic [STATE_W-1:0] even_q, odd_q, rd_data;

  back_state_t state, state_next;
  logic        cur_buf;
  logic [AW-1:0] clr_cnt;
  logic [CW-1:0] cx, cy, cz;
  logic [1:0]    kx, ky, kz;
  logic [NBR_W-1:0] count;
  logic [STATE_W-1:0] center;
  logic          p_issue, p_inb, p_center;
  logic          rd_inside;
  logic [STATE_W-1:0] res_rv;
  logic          res_done;

  logic          we_even, we_odd;
  logic [AW-1:0] wa, ra;
  logic [STATE_W-1:0] wd;

  logic [STATE_W-1:0] top;
  logic [CW:0]   ex, ey, ez;
  logic          inb;
  logic [CW-1:0] nx, ny, nz;
  logic [AW-1:0] item_addr, nbr_addr, cell_addr;
  logic [STATE_W-1:0] sat_value, gen_value;
  logic          k_last, cell_last, clr_last;
  logic          out_free;

  assign top       = top_of(cfg.state_count);
  assign ex        = {1'b0, cx} + (CW+1)'(kx);
  assign ey        = {1'b0, cy} + (CW+1)'(ky);
  assign ez        = {1'b0, cz} + (CW+1)'(kz);
  assign inb       = (ex != '0) && (ex <= (CW+1)'(SIDE)) && (ey != '0) &&
                     (ey <= (CW+1)'(SIDE)) && (ez != '0) && (ez <= (CW+1)'(SIDE));
  assign nx        = CW'(ex - (CW+1)'(1));
  assign ny        = CW'(ey - (CW+1)'(1));
  assign nz        = CW'(ez - (CW+1)'(1));
  assign item_addr = AW'((int'(q_item.z) * SIDE + int'(q_item.y)) * SIDE + int'(q_item.x));
  assign nbr_addr  = AW'((int'(nz) * SIDE + int'(ny)) * SIDE + int'(nx));
  assign cell_addr = AW'((int'(cz) * SIDE + int'(cy)) * SIDE + int'(cx));
  assign sat_value = (q_item.value > top) ? top : q_item.value;
  assign k_last    = (kx == 2'd2) && (ky == 2'd2) && (kz == 2'd2);
  assign cell_last = (cx == CW'(SIDE - 1)) && (cy == CW'(SIDE - 1)) && (cz == CW'(SIDE - 1));
  assign clr_last  = (clr_cnt == AW'(CELLS - 1));
  assign out_free  = !out_valid || out_ready;
  assign rd_data   = cur_buf ? odd_q : even_q;
  assign status.init_busy = (state == ST_CLEAR);

  // Generations rule; a cell at or above top counts as top
  always_comb begin
    if (center == '0)
      gen_value = cfg.birth[count] ? top : '0;
    else if (center >= top)
      gen_value = cfg.survive[count] ? top : top - STATE_W'(1);
    else
      gen_value = center - STATE_W'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            FUNC_READ: state_next = ST_RD_WAIT;
            FUNC_GEN:  state_next = ST_GEN_RD;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_RD_WAIT: state_next = ST_RESP;
      ST_GEN_RD:  if (k_last) state_next = ST_GEN_ACC;
      ST_GEN_ACC: state_next = ST_GEN_WR;
      ST_GEN_WR:  state_next = cell_last ? ST_RESP : ST_GEN_RD;
      ST_RESP:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    we_even = 1'b0;
    we_odd  = 1'b0;
    wa      = cell_addr;
    wd      = gen_value;
    ra      = nbr_addr;
    case (state)
      ST_CLEAR: begin
        we_even = 1'b1;
        we_odd  = 1'b1;
        wa      = clr_cnt;
        wd      = '0;
      end
      ST_IDLE: begin
        q_pop = q_valid;
        ra    = item_addr;
        wa    = item_addr;
        wd    = sat_value;
        if (q_valid && q_item.op == FUNC_WRITE && q_item.in_cube) begin
          we_even = !cur_buf;
          we_odd  = cur_buf;
        end
      end
      ST_GEN_WR: begin
        // next generation goes to the other buffer
        we_even = cur_buf;
        we_odd  = !cur_buf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_even) mem_even[wa] <= wd;
    if (we_odd)  mem_odd[wa]  <= wd;
    even_q <= mem_even[ra];
    odd_q  <= mem_odd[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_buf   <= 1'b0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      p_issue   <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if ((state == ST_RESP) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      p_issue <= (state == ST_GEN_RD);
      case (state)
        ST_IDLE: begin
          cx <= '0; cy <= '0; cz <= '0;
          kx <= '0; ky <= '0; kz <= '0;
          count     <= '0;
          rd_inside <= q_item.in_cube;
          res_rv    <= '0;
          res_done  <= (q_item.op != FUNC_NOP);
        end
        ST_RD_WAIT: res_rv <= rd_inside ? rd_data : '0;
        ST_GEN_RD: begin
          p_inb    <= inb;
          p_center <= (kx == 2'(CENTER_K)) && (ky == 2'(CENTER_K)) && (kz == 2'(CENTER_K));
          // advance the neighbor offset, x fastest
          if (kx != 2'd2) kx <= kx + 2'd1;
          else begin
            kx <= '0;
            if (ky != 2'd2) ky <= ky + 2'd1;
            else begin
              ky <= '0;
              kz <= kz + 2'd1;
            end
          end
        end
        ST_GEN_WR: begin
          kx <= '0; ky <= '0; kz <= '0;
          count <= '0;
          if (cx != CW'(SIDE - 1)) cx <= cx + CW'(1);
          else begin
            cx <= '0;
            if (cy != CW'(SIDE - 1)) cy <= cy + CW'(1);
            else begin
              cy <= '0;
              cz <= cz + CW'(1);
            end
          end
          if (cell_last) cur_buf <= !cur_buf;
        end
        ST_RESP: begin
          if (out_free) begin
            read_value <= res_rv;
            done_res   <= res_done;
          end
        end
        default: ;
      endcase
      if (p_issue && p_inb) begin
        if (p_center) center <= rd_data;
        else if (rd_data != '0) count <= count + NBR_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NBR_W'(26))
    else $error("neighbor count above 26");

  a_swap_end: assert property (@(posedge clk) disable iff (rst)
    (cur_buf != $past(cur_buf)) |-> $past(state) == ST_GEN_WR)
    else $error("buffer swap outside end of generation");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE) && q_valid)
    else $error("queue popped while busy");

endmodule

// ===== hdl/cellular_automaton_3d_generations.sv =====
// ----------------------------------------------------------------------------
// cellular_automaton_3d_generations
// 3D Generations cellular automaton on a SIDE^3 cube with Moore neighborhood.
// ----------------------------------------------------------------------------
// After reset the block clears both cell buffers, one cell a cycle, before it
// accepts the first item. Items pass through a two-entry queue to the
// executing side. A write or a no-op goes straight to the response; a read
// first waits for the registered read of the cell memory. In a generation
// each cell reads its 27 neighborhood positions one per cycle through the
// single read port, then accumulates and writes the new state to the other
// buffer. Configuration writes should only be issued idle.
module cellular_automaton_3d_generations #(
  parameter int SIDE = ca3g_pkg::SIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ca3g_pkg::MASK_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [ca3g_pkg::COORD_W-1:0]  pos_x,
  input  logic [ca3g_pkg::COORD_W-1:0]  pos_y,
  input  logic [ca3g_pkg::COORD_W-1:0]  pos_z,
  input  logic [ca3g_pkg::STATE_W-1:0]  cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ca3g_pkg::STATE_W-1:0]  read_value,
  output logic                          done_res
);
  import ca3g_pkg::*;

  cfg_t         cfg;
  back_status_t status;
  logic         q_valid;
  item_t        q_item;
  logic         q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.birth       <= MASK_W'(45280);
      cfg.survive     <= MASK_W'(134217216);
      cfg.state_count <= COUNT_W'(5);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIRTH:   cfg.birth       <= cfg_data;
        REG_SURVIVE: cfg.survive     <= cfg_data;
        REG_STATES:  cfg.state_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  ca3g_front #(.SIDE(SIDE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .cell_value (cell_value),
    .status     (status),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  ca3g_back #(.SIDE(SIDE)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .done_res   (done_res)
  );

endmodule
